// ===== rtl/itr_pkg.sv =====
// Shared types, constants and numeral step tables for the integer-to-Roman converter.
package itr_pkg;

	localparam int NUMBER_W    = 12;
	localparam int SYMBOL_W    = 7;
	localparam int STEPS       = 13;
	localparam int STEP_W      = 4;
	localparam int MAX_VALUE   = 3999;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [SYMBOL_W-1:0] CHAR_I = 7'h49;
	localparam logic [SYMBOL_W-1:0] CHAR_V = 7'h56;
	localparam logic [SYMBOL_W-1:0] CHAR_X = 7'h58;
	localparam logic [SYMBOL_W-1:0] CHAR_L = 7'h4C;
	localparam logic [SYMBOL_W-1:0] CHAR_C = 7'h43;
	localparam logic [SYMBOL_W-1:0] CHAR_D = 7'h44;
	localparam logic [SYMBOL_W-1:0] CHAR_M = 7'h4D;
	localparam logic [SYMBOL_W-1:0] CHAR_NONE = 7'h00;

	// One classified item waiting for the back end
	typedef struct packed {
		logic [NUMBER_W-1:0] number;
		logic                bad;
	} entry_t;

	function automatic logic [NUMBER_W-1:0] step_value(input logic [STEP_W-1:0] idx);
		logic [NUMBER_W-1:0] v;
		unique case (idx)
			4'd0:    v = 12'd1000;
			4'd1:    v = 12'd900;
			4'd2:    v = 12'd500;
			4'd3:    v = 12'd400;
			4'd4:    v = 12'd100;
			4'd5:    v = 12'd90;
			4'd6:    v = 12'd50;
			4'd7:    v = 12'd40;
			4'd8:    v = 12'd10;
			4'd9:    v = 12'd9;
			4'd10:   v = 12'd5;
			4'd11:   v = 12'd4;
			4'd12:   v = 12'd1;
			default: v = 12'd4095;
		endcase
		return v;
	endfunction

	function automatic logic [SYMBOL_W-1:0] step_first(input logic [STEP_W-1:0] idx);
		logic [SYMBOL_W-1:0] c;
		unique case (idx)
			4'd0, 4'd1, 4'd3:   c = CHAR_M;
			4'd2:               c = CHAR_D;
			4'd4, 4'd5, 4'd7:   c = CHAR_C;
			4'd6:               c = CHAR_L;
			4'd8, 4'd9, 4'd11:  c = CHAR_X;
			4'd10:              c = CHAR_V;
			4'd12:              c = CHAR_I;
			default:            c = CHAR_NONE;
		endcase
		// subtractive pairs open with the smaller symbol
		unique case (idx)
			4'd1, 4'd3:   c = CHAR_C;
			4'd5, 4'd7:   c = CHAR_X;
			4'd9, 4'd11:  c = CHAR_I;
			default:      c = c;
		endcase
		return c;
	endfunction

	function automatic logic [SYMBOL_W-1:0] step_second(input logic [STEP_W-1:0] idx);
		logic [SYMBOL_W-1:0] c;
		unique case (idx)
			4'd1:    c = CHAR_M;
			4'd3:    c = CHAR_D;
			4'd5:    c = CHAR_C;
			4'd7:    c = CHAR_L;
			4'd9:    c = CHAR_X;
			4'd11:   c = CHAR_V;
			default: c = CHAR_NONE;
		endcase
		return c;
	endfunction

	function automatic logic step_pair(input logic [STEP_W-1:0] idx);
		return (idx == 4'd1) || (idx == 4'd3) || (idx == 4'd5) ||
		       (idx == 4'd7) || (idx == 4'd9) || (idx == 4'd11);
	endfunction

endpackage

// ===== rtl/itr_front.sv =====
// Front end: takes input transactions and classifies each number as valid or out of range.
module itr_front (
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // [11:0] number
	input  logic                            q_full,
	output logic                            q_push,
	output itr_pkg::entry_t                 q_entry
);

	logic [itr_pkg::NUMBER_W-1:0] number;

	assign number   = s_tdata[itr_pkg::NUMBER_W-1:0];
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_entry.number = number;
		q_entry.bad    = (number == '0) ||
		                 (number > itr_pkg::NUMBER_W'(itr_pkg::MAX_VALUE));
	end

endmodule

// ===== rtl/itr_queue.sv =====
// Short queue of classified items between the front and back ends.
module itr_queue #(
	parameter int DEPTH = itr_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  itr_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output itr_pkg::entry_t head_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	itr_pkg::entry_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/itr_back.sv =====
// Back end: greedy numeral sequencer; one character per cycle unless stalled, into a register.
module itr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  itr_pkg::entry_t head_entry,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,   // [6:0] symbol
	output logic            m_tlast,
	output logic            m_tuser    // [0] bad_input
);

	logic                          busy_q;
	logic                          half_q;
	logic [itr_pkg::STEP_W-1:0]    step_q;
	logic [itr_pkg::NUMBER_W-1:0]  rest_q;
	logic                          valid_q;
	logic [itr_pkg::SYMBOL_W-1:0]  symbol_q;
	logic                          last_q;
	logic                          bad_q;

	logic                          advance;
	logic                          work;
	logic [itr_pkg::NUMBER_W-1:0]  cur_rest;
	logic [itr_pkg::STEP_W-1:0]    sel;
	logic [itr_pkg::NUMBER_W-1:0]  rest_nxt;

	assign advance  = !valid_q || m_tready;
	assign work     = advance && (busy_q || head_valid);
	assign pop      = advance && !busy_q && head_valid;
	assign cur_rest = busy_q ? rest_q : head_entry.number;

	// Largest step value that still fits in the remainder
	always_comb begin
		sel = itr_pkg::STEP_W'(itr_pkg::STEPS - 1);
		for (int s = itr_pkg::STEPS - 1; s >= 0; s--) begin
			if (cur_rest >= itr_pkg::step_value(itr_pkg::STEP_W'(s))) begin
				sel = itr_pkg::STEP_W'(s);
			end
		end
	end

	assign rest_nxt = cur_rest - itr_pkg::step_value(sel);

	always_ff @(posedge clk) begin
		if (work) begin
			if (busy_q && half_q) begin
				symbol_q <= itr_pkg::step_second(step_q);
				last_q   <= (rest_q == '0);
				bad_q    <= 1'b0;
			end else if (!busy_q && head_entry.bad) begin
				symbol_q <= itr_pkg::CHAR_NONE;
				last_q   <= 1'b1;
				bad_q    <= 1'b1;
			end else begin
				symbol_q <= itr_pkg::step_first(sel);
				last_q   <= !itr_pkg::step_pair(sel) && (rest_nxt == '0);
				bad_q    <= 1'b0;
				rest_q   <= rest_nxt;
				step_q   <= sel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			half_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= work;
			end
			if (work) begin
				if (busy_q && half_q) begin
					half_q <= 1'b0;
					busy_q <= (rest_q != '0);
				end else if (!busy_q && head_entry.bad) begin
					busy_q <= 1'b0;
					half_q <= 1'b0;
				end else begin
					// hold for the second symbol of a subtractive pair
					half_q <= itr_pkg::step_pair(sel);
					busy_q <= itr_pkg::step_pair(sel) || (rest_nxt != '0);
				end
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, symbol_q};
	assign m_tlast  = last_q;
	assign m_tuser  = bad_q;

endmodule

// ===== rtl/integer_to_roman.sv =====
// Top level of the integer-to-Roman numeral converter.
// Each input transaction carries a number in s_tdata[11:0]; a value from 1 to 3999 yields
// its Roman numeral as one ASCII character per output transaction, most significant symbol
// first, with m_tlast on the final character. Zero or a value above 3999 yields a single
// transaction with symbol 0, m_tuser and m_tlast high. The back end emits one character per
// cycle unless the output stalls; a numeral has 1 to 15 characters (one for an error), and a
// queue of QUEUE_DEPTH classified items lets input keep arriving while a numeral is being
// sent. Nothing is held between items.
module integer_to_roman #(
	parameter int QUEUE_DEPTH = itr_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] number
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] symbol
	output logic        m_tlast,
	output logic        m_tuser    // [0] bad_input
);

	logic            q_full;
	logic            q_push;
	itr_pkg::entry_t q_entry;
	logic            q_pop;
	logic            head_valid;
	itr_pkg::entry_t head_entry;

	itr_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	itr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	itr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== sim/itr_numeral_checker.sv =====
// Checker for the integer-to-Roman converter: spells accepted numbers, compares characters.
module itr_numeral_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] number
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [6:0] symbol
	input  logic        m_tlast,
	input  logic        m_tuser,   // [0] bad_input
	output int          mismatch_count,
	output int          chars_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [itr_pkg::SYMBOL_W-1:0] symbol;
		logic                         last;
		logic                         bad;
	} numeral_char_t;

	localparam int unsigned NUMERAL_WEIGHT [itr_pkg::STEPS] = '{
		1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
	};
	localparam logic [itr_pkg::SYMBOL_W-1:0] LEAD_CHAR [itr_pkg::STEPS] = '{
		itr_pkg::CHAR_M, itr_pkg::CHAR_C, itr_pkg::CHAR_D, itr_pkg::CHAR_C,
		itr_pkg::CHAR_C, itr_pkg::CHAR_X, itr_pkg::CHAR_L, itr_pkg::CHAR_X,
		itr_pkg::CHAR_X, itr_pkg::CHAR_I, itr_pkg::CHAR_V, itr_pkg::CHAR_I,
		itr_pkg::CHAR_I
	};
	localparam logic [itr_pkg::SYMBOL_W-1:0] TRAIL_CHAR [itr_pkg::STEPS] = '{
		itr_pkg::CHAR_NONE, itr_pkg::CHAR_M, itr_pkg::CHAR_NONE, itr_pkg::CHAR_D,
		itr_pkg::CHAR_NONE, itr_pkg::CHAR_C, itr_pkg::CHAR_NONE, itr_pkg::CHAR_L,
		itr_pkg::CHAR_NONE, itr_pkg::CHAR_X, itr_pkg::CHAR_NONE, itr_pkg::CHAR_V,
		itr_pkg::CHAR_NONE
	};

	numeral_char_t expected_chars[$];
	int            errors = 0;

	assign mismatch_count = errors;
	assign chars_pending  = expected_chars.size();

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Greedy expansion from the largest weight down; out-of-range gives one error transaction
	task automatic spell_numeral(input logic [itr_pkg::NUMBER_W-1:0] num);
		int unsigned   rest;
		numeral_char_t word[$];
		numeral_char_t ch;
		rest = num;
		if (rest == 0 || rest > itr_pkg::MAX_VALUE) begin
			ch.symbol = itr_pkg::CHAR_NONE;
			ch.last   = 1'b1;
			ch.bad    = 1'b1;
			expected_chars.push_back(ch);
		end else begin
			for (int s = 0; s < itr_pkg::STEPS; s++) begin
				while (rest >= NUMERAL_WEIGHT[s]) begin
					ch.symbol = LEAD_CHAR[s];
					ch.last   = 1'b0;
					ch.bad    = 1'b0;
					word.push_back(ch);
					if (TRAIL_CHAR[s] != itr_pkg::CHAR_NONE) begin
						ch.symbol = TRAIL_CHAR[s];
						word.push_back(ch);
					end
					rest -= NUMERAL_WEIGHT[s];
				end
			end
			foreach (word[k]) begin
				ch = word[k];
				ch.last = (k == word.size() - 1);
				expected_chars.push_back(ch);
			end
		end
	endtask

	// Take the input side first so a same-edge pass-through still lines up
	always @(posedge clk) begin
		numeral_char_t exp_ch;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				spell_numeral(s_tdata[itr_pkg::NUMBER_W-1:0]);
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction tdata=%02h tlast=%b tuser=%b",
						m_tdata, m_tlast, m_tuser));
				end else begin
					exp_ch = expected_chars.pop_front();
					if (m_tdata !== 8'(exp_ch.symbol))
						report_mismatch($sformatf("symbol %02h, expected %02h",
							m_tdata, 8'(exp_ch.symbol)));
					if (m_tlast !== exp_ch.last)
						report_mismatch($sformatf("tlast %b, expected %b", m_tlast, exp_ch.last));
					if (m_tuser !== exp_ch.bad)
						report_mismatch($sformatf("tuser %b, expected %b", m_tuser, exp_ch.bad));
				end
			end
		end
	end

endmodule

// ===== sim/integer_to_roman_tb.sv =====
// Testbench top for the integer-to-Roman converter: stimulus, stalls and the verdict.
module integer_to_roman_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	int mismatch_count;
	int chars_pending;
	int cycle_count = 0;
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	int stall_left = 0;

	integer_to_roman i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	itr_numeral_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.chars_pending  (chars_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("integer_to_roman_tb NOT OK");
			$finish;
		end
	end

	// Output stalls in random bursts, started only while snk_idle is set
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (snk_idle && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 8) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Hold tvalid until the transaction is taken; optionally idle first with junk on tdata
	task automatic send_number(input logic [itr_pkg::NUMBER_W-1:0] num);
		if (src_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 16'($urandom());
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= 16'(num);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(input int count);
		logic [itr_pkg::NUMBER_W-1:0] num;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0:       num = itr_pkg::NUMBER_W'($urandom_range(4000, 4095));
				1:       num = '0;
				2, 3:    num = itr_pkg::NUMBER_W'($urandom_range(1, 60));
				4:       num = itr_pkg::NUMBER_W'($urandom_range(3000, 3999));
				default: num = itr_pkg::NUMBER_W'($urandom_range(1, itr_pkg::MAX_VALUE));
			endcase
			send_number(num);
		end
	endtask

	initial begin
		int directed[$];
		directed = '{1, 2, 3, 4, 5, 9, 10, 14, 40, 49, 90, 99, 400, 444, 900,
		             999, 1000, 1994, 2048, 3888, 3999, 0, 4000, 4095, 1365};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k])
			send_number(itr_pkg::NUMBER_W'(directed[k]));
		send_random(25);
		// back-to-back stretch with no idling on either side
		src_idle = 1'b0;
		snk_idle = 1'b0;
		send_random(25);
		src_idle = 1'b1;
		snk_idle = 1'b1;
		send_random(40);
		src_idle = 1'b0;
		snk_idle = 1'b0;
		send_random(15);
		s_tvalid <= 1'b0;

		while (chars_pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && chars_pending == 0)
			$display("integer_to_roman_tb OK");
		else
			$display("integer_to_roman_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/itr_pkg.sv
rtl/itr_front.sv
rtl/itr_queue.sv
rtl/itr_back.sv
rtl/integer_to_roman.sv
sim/itr_numeral_checker.sv
sim/integer_to_roman_tb.sv
